// ===== rtl/core/b64d_pkg.sv =====
// Package of the base64 stream decoder: shared types, codes and the alphabet decode.
`default_nettype none
package b64d_pkg;

  localparam int unsigned SextetW    = 6;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned MaxResults = 3;
  localparam int unsigned CntW       = 2;
  localparam int unsigned QueueDepthDefault = 4;

  localparam logic [ByteW-1:0] CharPad     = 8'h3D;
  localparam logic [ByteW-1:0] CharNewline = 8'h0A;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_CHAR = 2'd1,
    STATUS_BAD_LEN  = 2'd2
  } status_e;

  // One result as it leaves the block.
  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             byte_valid;
    logic             message_end;
    status_e          status;
  } result_t;

  // Work handed from the front end to the back end: up to three results.
  typedef struct packed {
    logic [CntW-1:0]           cnt;
    result_t [MaxResults-1:0]  res;
  } cmd_t;

  // Decoded character: bad flag and the 6-bit value.
  typedef struct packed {
    logic              bad;
    logic [SextetW-1:0] value;
  } sextet_t;

  function automatic sextet_t sextet_of(input logic [ByteW-1:0] c);
    sextet_t s;
    s.bad   = 1'b0;
    s.value = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      s.value = SextetW'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      s.value = SextetW'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      s.value = SextetW'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      s.value = SextetW'(62);
    end else if (c == 8'h2F) begin
      s.value = SextetW'(63);
    end else begin
      s.bad = 1'b1;
    end
    return s;
  endfunction

  function automatic result_t byte_result(input logic [ByteW-1:0] b);
    result_t r;
    r.data_byte   = b;
    r.byte_valid  = 1'b1;
    r.message_end = 1'b0;
    r.status      = STATUS_OK;
    return r;
  endfunction

  function automatic result_t end_result(input status_e st);
    result_t r;
    r.data_byte   = '0;
    r.byte_valid  = 1'b0;
    r.message_end = 1'b1;
    r.status      = st;
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/b64d_if.sv =====
// Channel interfaces of the base64 stream decoder: character input and result output.
`default_nettype none
interface b64d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       final_char;

  modport source (output valid, output char_code, output final_char, input ready);
  modport sink   (input valid, input char_code, input final_char, output ready);
endinterface

interface b64d_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       message_end;
  logic [1:0] status;

  modport source (output valid, output data_byte, output byte_valid,
                  output message_end, output status, input ready);
  modport sink   (input valid, input data_byte, input byte_valid,
                  input message_end, input status, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/base64_stream_decoder.sv =====
// Top level of the base64 stream decoder: front end, result queue and back end.
//
// Usage: characters of base64 text enter on in_chan_i, one per request, with
// final_char raised on the last character of each message. Decoded bytes and
// end-of-message markers leave on out_chan_o, one result per request; the last
// result of every message has message_end set, and status reports an invalid
// character or a lone leftover value.
// Throughput: one character is taken per cycle while the queue has room. A
// fourth value of a group yields three results, which the back end sends in turn,
// so a plain stream of valid text keeps pace (four characters, three bytes).
// Path: a character accepted by the front end has its results written into the
// queue, and the back end loads the group from there into its register, from
// which the first result is offered.
// Stalls: the queue of result groups lets the front end go on accepting while
// the receiver holds ready low; once the queue is full, in_chan_i.ready drops
// until the back end takes a group. Characters that cause no result never
// wait on the receiver unless the queue is full.
// Reset: rst_ni clears the group count, the padding and error-drop flags and
// empties the queue; no clearing pass is needed.
`default_nettype none
module base64_stream_decoder #(
  parameter int unsigned QueueDepth = b64d_pkg::QueueDepthDefault
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  b64d_in_if.sink     in_chan_i,
  b64d_out_if.source  out_chan_o
);

  logic           push;
  b64d_pkg::cmd_t push_data;
  logic           full;
  logic           pop;
  logic           not_empty;
  b64d_pkg::cmd_t pop_data;

  // The front end classifies each character and updates the group state at
  // once; it stalls only when there is no room in the queue.
  b64d_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_chan     (in_chan_i),
    .cmd_valid_o (push),
    .cmd_o       (push_data),
    .cmd_ready_i (~full)
  );

  b64d_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .not_empty_o (not_empty),
    .pop_data_o  (pop_data)
  );

  // The back end holds one group and steps through its results as the
  // receiver takes them, loading the next group in the cycle the last goes.
  b64d_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (not_empty),
    .cmd_i       (pop_data),
    .cmd_pop_o   (pop),
    .out_chan    (out_chan_o)
  );

endmodule
`default_nettype wire

// ===== rtl/core/b64d_front.sv =====
// Front end: accepts characters, tracks the group state and forms the results of each one.
`default_nettype none
module b64d_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  b64d_in_if.sink              in_chan,
  output logic                 cmd_valid_o,
  output b64d_pkg::cmd_t       cmd_o,
  input  wire logic            cmd_ready_i
);

  logic [b64d_pkg::CntW-1:0]    gc_q, gc_d;
  logic                         pad_q, pad_d;
  logic                         drop_q, drop_d;
  logic [b64d_pkg::SextetW-1:0] held_q [3];
  logic [b64d_pkg::SextetW-1:0] held_d [3];

  logic                         accept;
  logic                         fin;
  logic [b64d_pkg::ByteW-1:0]   ch;
  b64d_pkg::sextet_t            sx;
  logic                         do_flush;
  b64d_pkg::cmd_t               cmd;

  assign in_chan.ready = cmd_ready_i;
  assign accept        = in_chan.valid & cmd_ready_i;
  assign ch            = in_chan.char_code;
  assign fin           = in_chan.final_char;
  assign sx            = b64d_pkg::sextet_of(ch);

  always_comb begin
    gc_d     = gc_q;
    pad_d    = pad_q;
    drop_d   = drop_q;
    held_d   = held_q;
    do_flush = 1'b0;
    cmd      = '0;

    if (drop_q) begin
      if (fin) begin
        drop_d = 1'b0;
      end
    end else if (pad_q) begin
      do_flush = fin;
    end else if (ch == b64d_pkg::CharPad) begin
      pad_d    = 1'b1;
      do_flush = fin;
    end else if (fin && ch == b64d_pkg::CharNewline) begin
      do_flush = 1'b1;
    end else if (sx.bad) begin
      cmd.cnt    = 2'd1;
      cmd.res[0] = b64d_pkg::end_result(b64d_pkg::STATUS_BAD_CHAR);
      gc_d       = '0;
      pad_d      = 1'b0;
      drop_d     = ~fin;
    end else if (gc_q == 2'd3) begin
      // Fourth value completes the group: three bytes at once.
      cmd.cnt    = 2'd3;
      cmd.res[0] = b64d_pkg::byte_result({held_q[0], held_q[1][5:4]});
      cmd.res[1] = b64d_pkg::byte_result({held_q[1][3:0], held_q[2][5:2]});
      cmd.res[2] = b64d_pkg::byte_result({held_q[2][1:0], sx.value});
      gc_d       = '0;
      do_flush   = fin;
    end else begin
      held_d[gc_q] = sx.value;
      gc_d         = gc_q + 2'd1;
      do_flush     = fin;
    end

    if (do_flush) begin
      if (cmd.cnt == 2'd3) begin
        cmd.res[2].message_end = 1'b1;
      end else begin
        unique case (gc_d)
          2'd0: begin
            cmd.cnt    = 2'd1;
            cmd.res[0] = b64d_pkg::end_result(b64d_pkg::STATUS_OK);
          end
          2'd1: begin
            cmd.cnt    = 2'd1;
            cmd.res[0] = b64d_pkg::end_result(b64d_pkg::STATUS_BAD_LEN);
          end
          2'd2: begin
            cmd.cnt    = 2'd1;
            cmd.res[0] = b64d_pkg::byte_result({held_d[0], held_d[1][5:4]});
            cmd.res[0].message_end = 1'b1;
          end
          default: begin
            cmd.cnt    = 2'd2;
            cmd.res[0] = b64d_pkg::byte_result({held_d[0], held_d[1][5:4]});
            cmd.res[1] = b64d_pkg::byte_result({held_d[1][3:0], held_d[2][5:2]});
            cmd.res[1].message_end = 1'b1;
          end
        endcase
      end
      gc_d   = '0;
      pad_d  = 1'b0;
      drop_d = 1'b0;
    end
  end

  assign cmd_valid_o = accept & (cmd.cnt != '0);
  assign cmd_o       = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gc_q   <= '0;
      pad_q  <= 1'b0;
      drop_q <= 1'b0;
    end else if (accept) begin
      gc_q   <= gc_d;
      pad_q  <= pad_d;
      drop_q <= drop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      held_q <= held_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/b64d_queue.sv =====
// Small queue of result groups between the front end and the back end.
`default_nettype none
module b64d_queue #(
  parameter int unsigned Depth = b64d_pkg::QueueDepthDefault
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  b64d_pkg::cmd_t       push_data_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 not_empty_o,
  output b64d_pkg::cmd_t       pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  b64d_pkg::cmd_t      mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     cnt_q;

  assign full_o      = (cnt_q == FullCnt);
  assign not_empty_o = (cnt_q != '0);
  assign pop_data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/b64d_back.sv =====
// Back end: takes queued groups, sends results one per cycle unless ready is low.
`default_nettype none
module b64d_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cmd_valid_i,
  input  b64d_pkg::cmd_t       cmd_i,
  output logic                 cmd_pop_o,
  b64d_out_if.source           out_chan
);

  b64d_pkg::cmd_t            cmd_q;
  logic                      busy_q;
  logic [b64d_pkg::CntW-1:0] idx_q;
  b64d_pkg::result_t         cur;
  logic                      sent;
  logic                      last_sent;

  assign cur       = cmd_q.res[idx_q];
  assign sent      = busy_q & out_chan.ready;
  assign last_sent = sent & (idx_q == cmd_q.cnt - 2'd1);
  assign cmd_pop_o = cmd_valid_i & (~busy_q | last_sent);

  assign out_chan.valid       = busy_q;
  assign out_chan.data_byte   = cur.data_byte;
  assign out_chan.byte_valid  = cur.byte_valid;
  assign out_chan.message_end = cur.message_end;
  assign out_chan.status      = cur.status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (cmd_pop_o) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (last_sent) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (sent) begin
      idx_q  <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q <= cmd_i;
    end
  end

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the base64 stream decoder: directed table, random messages.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import b64d_pkg::*;

  // Random messages stop once this many characters have been sent to the
  // decoder, the directed table included.
  localparam int unsigned ItemsTarget = 430;
  // Generous ceiling on the whole run, far above the slowest legal run.
  localparam int unsigned RunLimitNs = 3_000_000;

  // Results whose value can be read straight off the decoding rules.
  localparam result_t EndOk      = '{data_byte: 8'h00, byte_valid: 1'b0,
                                     message_end: 1'b1, status: STATUS_OK};
  localparam result_t EndBadChar = '{data_byte: 8'h00, byte_valid: 1'b0,
                                     message_end: 1'b1, status: STATUS_BAD_CHAR};
  localparam result_t EndBadLen  = '{data_byte: 8'h00, byte_valid: 1'b0,
                                     message_end: 1'b1, status: STATUS_BAD_LEN};
  localparam result_t NoResult   = '0;

  logic clk_i;
  logic rst_ni;

  b64d_in_if  chars_if ();
  b64d_out_if bytes_if ();

  base64_stream_decoder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_chan_i  (chars_if),
    .out_chan_o (bytes_if)
  );

  // ---------------------------------------------------------------------------
  // Directed stimulus. Rows marked as typed carry the single result that the
  // character must produce; every other row is checked against the decoder
  // model below.
  // ---------------------------------------------------------------------------
  typedef struct {
    logic [7:0] ch;
    logic       fin;
    bit         typed;
    result_t    want;
  } dir_row_t;

  dir_row_t dir_tab [25] = '{
    // A lone pad straight after reset flushes an empty group.
    '{CharPad,     1'b1, 1'b1, EndOk},
    // A single value on its own is a length error.
    '{"A",         1'b1, 1'b1, EndBadLen},
    // A character outside the alphabet ends the message at once.
    '{"!",         1'b1, 1'b1, EndBadChar},
    // A final newline with nothing held flushes an empty group.
    '{CharNewline, 1'b1, 1'b1, EndOk},
    // Highest value in every position: three bytes of all ones.
    '{"/",         1'b0, 1'b0, NoResult},
    '{"/",         1'b0, 1'b0, NoResult},
    '{"/",         1'b0, 1'b0, NoResult},
    '{"/",         1'b1, 1'b0, NoResult},
    // Edges of the letter and digit ranges.
    '{"Z",         1'b0, 1'b0, NoResult},
    '{"a",         1'b0, 1'b0, NoResult},
    '{"z",         1'b0, 1'b0, NoResult},
    '{"0",         1'b1, 1'b0, NoResult},
    // Two values, then padding: one byte once the final pad arrives.
    '{"9",         1'b0, 1'b0, NoResult},
    '{"+",         1'b0, 1'b0, NoResult},
    '{CharPad,     1'b0, 1'b0, NoResult},
    '{CharPad,     1'b1, 1'b0, NoResult},
    // Three values closed by a trailing newline: two bytes.
    '{"Q",         1'b0, 1'b0, NoResult},
    '{"Q",         1'b0, 1'b0, NoResult},
    '{"Q",         1'b0, 1'b0, NoResult},
    '{CharNewline, 1'b1, 1'b0, NoResult},
    // An invalid character mid-message; the rest is dropped silently.
    '{"A",         1'b0, 1'b0, NoResult},
    '{8'hFF,       1'b0, 1'b1, EndBadChar},
    '{"B",         1'b0, 1'b0, NoResult},
    '{8'h00,       1'b1, 1'b0, NoResult},
    // The top-bit character is outside the alphabet as well.
    '{8'h80,       1'b1, 1'b1, EndBadChar}
  };

  // ---------------------------------------------------------------------------
  // Decoder model: its own copy of the group state, updated once per accepted
  // request on the character channel.
  // ---------------------------------------------------------------------------
  logic [1:0] grp_cnt;
  logic [5:0] held [3];
  logic       pad_flag;
  logic       drop_flag;
  result_t    char_results [$];   // results of the character just decoded
  result_t    decoded_q [$];      // results still awaited on the output

  int unsigned chars_sent;
  int unsigned decoded_cnt;
  int unsigned burst_left;
  int unsigned err_cnt;
  int unsigned results_checked;
  int unsigned msgs_ended;
  int unsigned bad_char_seen;
  int unsigned bad_len_seen;

  function automatic result_t make_result(input logic [7:0] b, input logic v,
                                          input logic e, input status_e s);
    result_t r;
    r.data_byte   = b;
    r.byte_valid  = v;
    r.message_end = e;
    r.status      = s;
    return r;
  endfunction

  // Returns 1 and the 6-bit value when the character belongs to the alphabet.
  function automatic bit sextet_lookup(input logic [7:0] c, output logic [5:0] v);
    v = '0;
    if (c >= "A" && c <= "Z") begin
      v = 6'(c - "A");
    end else if (c >= "a" && c <= "z") begin
      v = 6'(c - "a" + 8'd26);
    end else if (c >= "0" && c <= "9") begin
      v = 6'(c - "0" + 8'd52);
    end else if (c == "+") begin
      v = 6'd62;
    end else if (c == "/") begin
      v = 6'd63;
    end else begin
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // Character that encodes the given value.
  function automatic logic [7:0] alphabet_char(input logic [5:0] v);
    if (v < 6'd26) begin
      return 8'("A" + v);
    end else if (v < 6'd52) begin
      return 8'("a" + v - 6'd26);
    end else if (v < 6'd62) begin
      return 8'("0" + v - 6'd52);
    end else if (v == 6'd62) begin
      return "+";
    end
    return "/";
  endfunction

  function automatic void close_message();
    grp_cnt   = '0;
    pad_flag  = 1'b0;
    drop_flag = 1'b0;
  endfunction

  // End of message: emit what the partial group still holds.
  function automatic void flush_group();
    case (grp_cnt)
      2'd0: begin
        if (char_results.size() > 0) begin
          char_results[char_results.size()-1].message_end = 1'b1;
        end else begin
          char_results.push_back(EndOk);
        end
      end
      2'd1: begin
        char_results.push_back(EndBadLen);
      end
      2'd2: begin
        char_results.push_back(make_result({held[0], held[1][5:4]}, 1'b1, 1'b1,
                                           STATUS_OK));
      end
      default: begin
        char_results.push_back(make_result({held[0], held[1][5:4]}, 1'b1, 1'b0,
                                           STATUS_OK));
        char_results.push_back(make_result({held[1][3:0], held[2][5:2]}, 1'b1, 1'b1,
                                           STATUS_OK));
      end
    endcase
    close_message();
  endfunction

  // Works out the results of one character into char_results. Returns 0 when
  // the decoder merely ignores the character.
  function automatic bit decode_char(input logic [7:0] c, input logic fin);
    logic [5:0] v;
    bit         counted;
    char_results.delete();
    counted = 1'b1;
    if (drop_flag) begin
      if (fin) close_message();
      counted = 1'b0;
    end else if (pad_flag) begin
      if (fin) flush_group();
      else counted = 1'b0;
    end else if (c == CharPad) begin
      pad_flag = 1'b1;
      if (fin) flush_group();
    end else if (fin && c == CharNewline) begin
      flush_group();
    end else if (!sextet_lookup(c, v)) begin
      char_results.push_back(EndBadChar);
      close_message();
      drop_flag = !fin;
    end else begin
      if (grp_cnt == 2'd3) begin
        char_results.push_back(make_result({held[0], held[1][5:4]}, 1'b1, 1'b0,
                                           STATUS_OK));
        char_results.push_back(make_result({held[1][3:0], held[2][5:2]}, 1'b1, 1'b0,
                                           STATUS_OK));
        char_results.push_back(make_result({held[2][1:0], v}, 1'b1, 1'b0, STATUS_OK));
        grp_cnt = '0;
      end else begin
        held[grp_cnt] = v;
        grp_cnt       = grp_cnt + 2'd1;
      end
      if (fin) flush_group();
    end
    return counted;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, and the limit on the whole run.
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(RunLimitNs);
    $display("Timeout at %0t: the run did not complete.", $time);
    $display("Mismatches found");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Character sender. It works in bursts of random length separated by random
  // gaps, now and then long ones; some bursts start with no gap at all. Inputs
  // change on the falling edge; a request is taken at the rising edge where
  // valid and ready are both high.
  // ---------------------------------------------------------------------------
  task automatic send_char(input logic [7:0] c, input logic fin, input bit typed,
                           input result_t want);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        @(negedge clk_i);
        chars_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    @(negedge clk_i);
    chars_if.valid      <= 1'b1;
    chars_if.char_code  <= c;
    chars_if.final_char <= fin;
    do @(posedge clk_i); while (chars_if.ready !== 1'b1);
    // The request has been taken at this edge: update the model.
    chars_sent++;
    if (decode_char(c, fin)) decoded_cnt++;
    if (typed) begin
      decoded_q.push_back(want);
    end else begin
      foreach (char_results[i]) decoded_q.push_back(char_results[i]);
    end
    burst_left--;
  endtask

  // Holds the sender off until every awaited result has come out.
  task automatic wait_drained();
    @(negedge clk_i);
    chars_if.valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
    burst_left = 0;
  endtask

  // One random message. Most are well-formed text of random length, with or
  // without padding or a trailing newline; some have a stray character put in
  // somewhere; the rest are raw bytes of any value.
  task automatic send_random_message();
    logic [7:0]  msg [$];
    logic [7:0]  junk;
    logic [5:0]  unused_v;
    int unsigned kind;
    int unsigned n;
    kind = $urandom_range(0, 9);
    if (kind <= 7) begin
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 24) : $urandom_range(0, 9);
      repeat (n) msg.push_back(alphabet_char(6'($urandom_range(0, 63))));
      case ($urandom_range(0, 4))
        2: repeat ($urandom_range(1, 2)) msg.push_back(CharPad);
        3: msg.push_back(CharNewline);
        4: begin
          // Anything after a pad is ignored up to the final character.
          msg.push_back(CharPad);
          msg.push_back(8'($urandom_range(0, 255)));
          msg.push_back(CharNewline);
        end
        default: ;
      endcase
      if (kind >= 6) begin
        do junk = 8'($urandom_range(0, 255)); while (sextet_lookup(junk, unused_v));
        msg.insert($urandom_range(0, msg.size()), junk);
      end
    end else begin
      repeat ($urandom_range(1, 8)) msg.push_back(8'($urandom_range(0, 255)));
    end
    if (msg.size() == 0) msg.push_back(CharNewline);
    foreach (msg[i]) send_char(msg[i], i == msg.size() - 1, 1'b0, NoResult);
  endtask

  // ---------------------------------------------------------------------------
  // Result receiver. It changes its stall pattern after each span of random
  // length: always ready, random, one cycle in three, or ready only one cycle
  // in twelve.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned mode;
    int unsigned span;
    int unsigned phase;
    bytes_if.ready = 1'b0;
    phase = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 80);
      repeat (span) begin
        @(negedge clk_i);
        phase++;
        case (mode)
          0:       bytes_if.ready <= 1'b1;
          1:       bytes_if.ready <= 1'($urandom_range(0, 1));
          2:       bytes_if.ready <= (phase % 3 == 0);
          default: bytes_if.ready <= (phase % 12 == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: each request on the output is compared, field by field,
  // with the oldest awaited result.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && bytes_if.valid === 1'b1 && bytes_if.ready === 1'b1) begin
      if (decoded_q.size() == 0) begin
        $display("ERROR %0t: result with none awaited: byte %h valid %b end %b status %0d",
                 $time, bytes_if.data_byte, bytes_if.byte_valid,
                 bytes_if.message_end, bytes_if.status);
        err_cnt++;
      end else begin
        want = decoded_q.pop_front();
        if (bytes_if.data_byte !== want.data_byte) begin
          $display("ERROR %0t: data_byte expected %h, got %h",
                   $time, want.data_byte, bytes_if.data_byte);
          err_cnt++;
        end
        if (bytes_if.byte_valid !== want.byte_valid) begin
          $display("ERROR %0t: byte_valid expected %b, got %b",
                   $time, want.byte_valid, bytes_if.byte_valid);
          err_cnt++;
        end
        if (bytes_if.message_end !== want.message_end) begin
          $display("ERROR %0t: message_end expected %b, got %b",
                   $time, want.message_end, bytes_if.message_end);
          err_cnt++;
        end
        if (bytes_if.status !== want.status) begin
          $display("ERROR %0t: status expected %0d, got %0d",
                   $time, want.status, bytes_if.status);
          err_cnt++;
        end
        results_checked++;
        if (want.message_end) msgs_ended++;
        if (want.status == STATUS_BAD_CHAR) bad_char_seen++;
        if (want.status == STATUS_BAD_LEN) bad_len_seen++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed table, random messages, drain and verdict.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned msg_no;
    chars_if.valid      = 1'b0;
    chars_if.char_code  = '0;
    chars_if.final_char = 1'b0;
    rst_ni              = 1'b0;
    grp_cnt             = '0;
    held                = '{default: '0};
    pad_flag            = 1'b0;
    drop_flag           = 1'b0;
    chars_sent          = 0;
    decoded_cnt         = 0;
    burst_left          = 0;
    err_cnt             = 0;
    results_checked     = 0;
    msgs_ended          = 0;
    bad_char_seen       = 0;
    bad_len_seen        = 0;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[i]) send_char(dir_tab[i].ch, dir_tab[i].fin, dir_tab[i].typed,
                                   dir_tab[i].want);
    // Let the output run dry before the random part begins.
    wait_drained();

    msg_no = 0;
    while (chars_sent < ItemsTarget) begin
      send_random_message();
      msg_no++;
      // Every tenth message the sender waits for the output to empty.
      if (msg_no % 10 == 0) wait_drained();
    end

    @(negedge clk_i);
    chars_if.valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
    // Keep the clock running so that any stray result would still be caught.
    repeat (8) @(posedge clk_i);

    $display("Run covered %0d characters (%0d decoded) and %0d results over %0d messages.",
             chars_sent, decoded_cnt, results_checked, msgs_ended);
    $display("Messages ended by an invalid character: %0d, by a lone value: %0d.",
             bad_char_seen, bad_len_seen);
    if (err_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
